[rtl/mrm_pkg.sv]
// ----------------------------------------------------------------------------
// mrm_pkg - shared types and constants of the Modbus RTU master engine
// Request, result and configuration codes, the result bundle passed from the
// transaction core to the result serialiser, and the CRC-16/Modbus matrix.
// ----------------------------------------------------------------------------
package mrm_pkg;

   // request kinds (req_tuser)
   localparam logic [1:0] KIND_REQUEST = 2'd0;
   localparam logic [1:0] KIND_BYTE    = 2'd1;
   localparam logic [1:0] KIND_TICK    = 2'd2;

   // result kinds (rsp_tuser)
   localparam logic [1:0] OUT_TX     = 2'd0;
   localparam logic [1:0] OUT_RX     = 2'd1;
   localparam logic [1:0] OUT_FINISH = 2'd2;

   // finish reasons
   localparam logic [1:0] REASON_FULL    = 2'd0;
   localparam logic [1:0] REASON_GAP     = 2'd1;
   localparam logic [1:0] REASON_TIMEOUT = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_FRAME_GAP   = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT     = 2'd1;
   localparam logic [1:0] CSR_MAX_RSP_LEN = 2'd2;

   // configuration reset values
   localparam logic [7:0]  FRAME_GAP_RESET   = 8'd5;
   localparam logic [15:0] TIMEOUT_RESET     = 16'd1000;
   localparam logic [8:0]  MAX_RSP_LEN_RESET = 9'd256;

   // Modbus function codes
   localparam logic [7:0] FC_READ_HOLDING = 8'h03;
   localparam logic [7:0] FC_READ_INPUT   = 8'h04;

   localparam logic [8:0]  BUF_MAX     = 9'd256;
   localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
   localparam logic [8:0]  SILENCE_MAX = 9'h1FF;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef struct packed {
      logic [7:0]  frame_gap_ms;
      logic [15:0] response_timeout_ms;
      logic [8:0]  max_response_len;
   } mrm_cfg_type;

   typedef struct packed {
      logic            has_tx;
      logic            has_rx;
      logic            has_fin;
      logic [7:0][7:0] tx_frame;
      logic [7:0]      rx_byte;
      logic [7:0]      rx_index;
      logic [8:0]      fin_count;
      logic [1:0]      fin_reason;
   } mrm_bundle_type;

   typedef struct packed {
      logic           valid;
      mrm_bundle_type bundle;
   } mrm_push_type;

   typedef logic [47:0][15:0] crc_cols_type;

   // Bitwise CRC over six bytes, byte 0 in the low bits; elaboration use only.
   function automatic logic [15:0] crc_bits(logic [47:0] msg, logic [15:0] init);
      logic [15:0] c;
      c = init;
      for (int j = 0; j < 6; j++) begin
         c = c ^ {8'h00, msg[j*8 +: 8]};
         for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         end
      end
      return c;
   endfunction

   function automatic crc_cols_type crc_columns();
      crc_cols_type cols;
      for (int i = 0; i < 48; i++) begin
         cols[i] = crc_bits(48'(1) << i, 16'h0000);
      end
      return cols;
   endfunction

   localparam crc_cols_type CRC_COLS      = crc_columns();
   localparam logic [15:0]  CRC_INIT_TERM = crc_bits(48'h0, CRC_INIT);

   // CRC is linear: each message bit toggles a fixed column, one XOR tree per CRC bit
   function automatic logic [15:0] crc_frame(logic [47:0] msg);
      logic [15:0] c;
      c = CRC_INIT_TERM;
      for (int i = 0; i < 48; i++) begin
         c = c ^ (msg[i] ? CRC_COLS[i] : 16'h0000);
      end
      return c;
   endfunction

endpackage

[rtl/mrm_csr.sv]
// ----------------------------------------------------------------------------
// mrm_csr - configuration registers
// Holds frame gap, response timeout and maximum response length.
// ----------------------------------------------------------------------------
module mrm_csr import mrm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output mrm_cfg_type cfg
);

   mrm_cfg_type cfg_ff;
   mrm_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_GAP:   cfg_in.frame_gap_ms        = csr_data[7:0];
            CSR_TIMEOUT:     cfg_in.response_timeout_ms = csr_data;
            CSR_MAX_RSP_LEN: cfg_in.max_response_len    = csr_data[8:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_gap_ms        <= FRAME_GAP_RESET;
         cfg_ff.response_timeout_ms <= TIMEOUT_RESET;
         cfg_ff.max_response_len    <= MAX_RSP_LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/mrm_core.sv]
// ----------------------------------------------------------------------------
// mrm_core - transaction core
// Registers each request, updates the receive state and timers, and builds
// the bundle of results that the request causes.
// ----------------------------------------------------------------------------
module mrm_core import mrm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,
   input  logic [1:0]   req_tuser,
   input  mrm_cfg_type  cfg,
   input  logic         emit_free,
   output mrm_push_type push
);

   logic        in_valid_ff;
   logic [1:0]  in_kind_ff;
   logic [48:0] in_data_ff;

   logic        receiving_ff, receiving_in;
   logic [8:0]  rcvd_ff, rcvd_in;
   logic [16:0] elapsed_ff, elapsed_in;
   logic [8:0]  silence_ff, silence_in;

   logic [7:0]  slave_address;
   logic        read_input_regs;
   logic [15:0] first_register;
   logic [15:0] register_count;
   logic [7:0]  rx_byte;

   logic [8:0]     acc_len;
   logic [8:0]     rcvd_inc;
   logic [16:0]    elapsed_inc;
   logic [8:0]     silence_inc;
   logic [15:0]    crc;
   mrm_bundle_type bnd;
   logic           has_result;
   logic           consume;

   assign slave_address   = in_data_ff[7:0];
   assign read_input_regs = in_data_ff[8];
   assign first_register  = in_data_ff[24:9];
   assign register_count  = in_data_ff[40:25];
   assign rx_byte         = in_data_ff[48:41];

   assign acc_len = (cfg.max_response_len > BUF_MAX) ? BUF_MAX : cfg.max_response_len;

   assign rcvd_inc    = 9'(rcvd_ff + 9'd1);
   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : 17'(elapsed_ff + 17'd1);
   assign silence_inc = (silence_ff == SILENCE_MAX) ? silence_ff : 9'(silence_ff + 9'd1);

   always_comb begin
      bnd          = '0;
      receiving_in = receiving_ff;
      rcvd_in      = rcvd_ff;
      elapsed_in   = elapsed_ff;
      silence_in   = silence_ff;

      bnd.tx_frame[0] = slave_address;
      bnd.tx_frame[1] = read_input_regs ? FC_READ_INPUT : FC_READ_HOLDING;
      bnd.tx_frame[2] = first_register[15:8];
      bnd.tx_frame[3] = first_register[7:0];
      bnd.tx_frame[4] = register_count[15:8];
      bnd.tx_frame[5] = register_count[7:0];
      crc             = crc_frame({bnd.tx_frame[5], bnd.tx_frame[4], bnd.tx_frame[3],
                                   bnd.tx_frame[2], bnd.tx_frame[1], bnd.tx_frame[0]});
      bnd.tx_frame[6] = crc[7:0];
      bnd.tx_frame[7] = crc[15:8];

      case (in_kind_ff)
         KIND_REQUEST: begin
            if (!receiving_ff) begin
               bnd.has_tx   = 1'b1;
               receiving_in = 1'b1;
               rcvd_in      = '0;
               elapsed_in   = '0;
               silence_in   = '0;
               if (acc_len == 9'd0) begin
                  bnd.has_fin    = 1'b1;
                  bnd.fin_reason = REASON_FULL;
                  receiving_in   = 1'b0;
               end
            end
         end
         KIND_BYTE: begin
            if (receiving_ff) begin
               bnd.has_rx   = 1'b1;
               bnd.rx_byte  = rx_byte;
               bnd.rx_index = rcvd_ff[7:0];
               rcvd_in      = rcvd_inc;
               silence_in   = '0;
               if (rcvd_inc >= acc_len) begin
                  bnd.has_fin    = 1'b1;
                  bnd.fin_count  = rcvd_inc;
                  bnd.fin_reason = REASON_FULL;
                  receiving_in   = 1'b0;
               end
            end
         end
         KIND_TICK: begin
            if (receiving_ff) begin
               elapsed_in    = elapsed_inc;
               silence_in    = silence_inc;
               bnd.fin_count = rcvd_ff;
               if (rcvd_ff >= acc_len) begin
                  bnd.has_fin    = 1'b1;
                  bnd.fin_reason = REASON_FULL;
               end else if (elapsed_inc > {1'b0, cfg.response_timeout_ms}) begin
                  bnd.has_fin    = 1'b1;
                  bnd.fin_reason = REASON_TIMEOUT;
               end else if ((rcvd_ff != 9'd0) && (silence_inc > {1'b0, cfg.frame_gap_ms})) begin
                  bnd.has_fin    = 1'b1;
                  bnd.fin_reason = REASON_GAP;
               end
               if (bnd.has_fin) begin
                  receiving_in = 1'b0;
               end
            end
         end
         default: begin
            bnd.has_fin = 1'b0;
         end
      endcase
   end

   assign has_result  = bnd.has_tx | bnd.has_rx | bnd.has_fin;
   // drop result-free requests at once, hold others until the serialiser frees
   assign consume     = in_valid_ff & (~has_result | emit_free);
   assign req_tready  = ~in_valid_ff | consume;
   assign push.valid  = in_valid_ff & has_result & emit_free;
   assign push.bundle = bnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         receiving_ff <= 1'b0;
         rcvd_ff      <= '0;
         elapsed_ff   <= '0;
         silence_ff   <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (consume) begin
            receiving_ff <= receiving_in;
            rcvd_ff      <= rcvd_in;
            elapsed_ff   <= elapsed_in;
            silence_ff   <= silence_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff <= req_tuser;
         in_data_ff <= req_tdata[48:0];
      end
   end

`ifndef SYNTHESIS
   a_fall_has_finish: assert property (@(posedge clock) disable iff (reset)
      $fell(receiving_ff) |-> $past(push.valid && push.bundle.has_fin))
      else $error("reception ended without a finish result");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      rcvd_ff <= BUF_MAX)
      else $error("received byte count beyond buffer size");

   a_push_when_free: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> emit_free && consume)
      else $error("bundle pushed while serialiser busy");
`endif

endmodule

[rtl/mrm_emit.sv]
// ----------------------------------------------------------------------------
// mrm_emit - result serialiser
// Holds one result bundle and sends its results one a cycle while rsp_tready is high, last marked.
// ----------------------------------------------------------------------------
module mrm_emit import mrm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  mrm_push_type push,
   output logic         emit_free,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);

   logic           bnd_valid_ff;
   mrm_bundle_type bnd_ff;
   logic [3:0]     pos_ff;

   logic [3:0] n_results;
   logic       take;
   logic [1:0] out_kind;
   logic [7:0] out_byte;
   logic [7:0] out_index;
   logic [8:0] out_count;
   logic [1:0] out_reason;

   assign n_results = (bnd_ff.has_tx ? 4'd8 : {3'b000, bnd_ff.has_rx})
                      + {3'b000, bnd_ff.has_fin};

   always_comb begin
      out_kind   = OUT_FINISH;
      out_byte   = '0;
      out_index  = '0;
      out_count  = bnd_ff.fin_count;
      out_reason = bnd_ff.fin_reason;
      if (bnd_ff.has_tx && !pos_ff[3]) begin
         out_kind   = OUT_TX;
         out_byte   = bnd_ff.tx_frame[pos_ff[2:0]];
         out_index  = {5'b00000, pos_ff[2:0]};
         out_count  = '0;
         out_reason = '0;
      end else if (bnd_ff.has_rx && pos_ff == 4'd0) begin
         out_kind   = OUT_RX;
         out_byte   = bnd_ff.rx_byte;
         out_index  = bnd_ff.rx_index;
         out_count  = '0;
         out_reason = '0;
      end
   end

   assign rsp_tvalid = bnd_valid_ff;
   assign rsp_tlast  = (pos_ff == 4'(n_results - 4'd1));
   assign rsp_tuser  = out_kind;
   assign rsp_tdata  = {5'b00000, out_reason, out_count, out_index, out_byte};

   assign take      = bnd_valid_ff & rsp_tready;
   assign emit_free = ~bnd_valid_ff | (take & rsp_tlast);

   always_ff @(posedge clock) begin
      if (reset) begin
         bnd_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         if (push.valid) begin
            bnd_valid_ff <= 1'b1;
            pos_ff       <= '0;
         end else if (take) begin
            if (rsp_tlast) begin
               bnd_valid_ff <= 1'b0;
               pos_ff       <= '0;
            end else begin
               pos_ff <= 4'(pos_ff + 4'd1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         bnd_ff <= push.bundle;
      end
   end

`ifndef SYNTHESIS
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      bnd_valid_ff |-> pos_ff < n_results)
      else $error("result position beyond bundle size");

   a_tx_rx_exclusive: assert property (@(posedge clock) disable iff (reset)
      bnd_valid_ff |-> !(bnd_ff.has_tx && bnd_ff.has_rx))
      else $error("bundle holds both transmit and receive results");

   a_advance_on_take: assert property (@(posedge clock) disable iff (reset)
      ($past(bnd_valid_ff && !rsp_tready) && !$past(push.valid)) |-> $stable(pos_ff))
      else $error("result position moved while stalled");
`endif

endmodule

[rtl/modbus_rtu_master_transaction.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_master_transaction - Modbus RTU master read transaction engine
// Builds FC03/FC04 request frames with CRC-16/Modbus, passes response bytes
// through with their index and ends reception on full, gap or timeout.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Payload                                          Handshake
// req_     in   tuser kind; tdata slave/fc sel/start/count/byte  tvalid/tready
// rsp_     out  tuser kind; tdata byte/index/count/reason; tlast tvalid/tready
// csr_     in   index 0..2, 16-bit write data                    valid/ready
//
// Cycles: a request passes an input register and a single combinational
// step into a result bundle, which the serialiser registers once it is free;
// the first result is offered from that register. The serialiser sends one
// result a cycle while rsp_tready is high, so a start request yields 8 or 9
// results, a byte one or two and a tick at most one; requests that cause no
// result are dropped without waiting for the serialiser.
// Reset: synchronous, active high; clears the receive state, timers, the
// pipeline valids and restores the configuration defaults (5, 1000, 256).
// Stalls: rsp_tready low holds the current result; the input register keeps
// taking requests until it holds one whose bundle cannot yet be loaded.
//
module modbus_rtu_master_transaction import mrm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] slave_address, [8] read_input_regs, [24:9] first_register,
   // [40:25] register_count, [48:41] rx_byte, [55:49] zero
   input  logic [55:0] req_tdata,
   // [1:0] kind
   input  logic [1:0]  req_tuser,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_byte, [15:8] out_index, [24:16] byte_count,
   // [26:25] finish_reason, [31:27] zero
   output logic [31:0] rsp_tdata,
   // [1:0] out_kind
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   mrm_cfg_type  cfg;
   mrm_push_type push;
   logic         emit_free;

   // configuration registers
   mrm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // input register, receive state and result bundle build
   mrm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg),
      .emit_free  (emit_free),
      .push       (push)
   );

   // hold the bundle and send its results in order
   mrm_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .emit_free  (emit_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
